// File: sv/sccl_pkg.sv
// Package for the snooping coherent cache lookup block.
// Holds the geometry constants, line state and action codes, and payload types.
// Depends on nothing; imported by snooping_coherent_cache_lookup.
package sccl_pkg;

	localparam int WAYS           = 4;
	localparam int SET_INDEX_BITS = 6;
	localparam int OFFSET_BITS    = 5;

	localparam int ADDR_BITS = 32;
	localparam int TAG_BITS  = ADDR_BITS - SET_INDEX_BITS - OFFSET_BITS;
	localparam int NSETS     = 1 << SET_INDEX_BITS;
	localparam int SET_W     = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
	localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef enum logic [1:0] {
		ST_INVALID  = 2'd0,
		ST_VALID    = 2'd1,
		ST_SHARED   = 2'd2,
		ST_MODIFIED = 2'd3
	} line_state_t;

	typedef enum logic [1:0] {
		FN_LOAD   = 2'd0,
		FN_STORE  = 2'd1,
		FN_BUS_RD = 2'd2,
		FN_BUS_RDX = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_VI   = 2'd1,
		MODE_MSI  = 2'd2,
		MODE_MSI_ALT = 2'd3
	} mode_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] address;
		logic [1:0]           func;
	} in_item_t;

	typedef struct packed {
		logic       hit;
		logic       writeback;
		logic       upgrade;
		logic [1:0] way_used;
	} out_item_t;

	typedef struct packed {
		logic [WAYS-1:0][TAG_BITS-1:0] tag;
		line_state_t [WAYS-1:0]        st;
		logic [WAYS-1:0]               dirty;
		logic [WAY_BITS-1:0]           victim;
	} set_row_t;

	function automatic logic [SET_W-1:0] set_of(input logic [ADDR_BITS-1:0] addr);
		logic [ADDR_BITS-1:0] sh;
		sh = (addr >> OFFSET_BITS) & ADDR_BITS'(NSETS - 1);
		return sh[SET_W-1:0];
	endfunction

	function automatic logic [TAG_BITS-1:0] tag_of(input logic [ADDR_BITS-1:0] addr);
		logic [ADDR_BITS-1:0] sh;
		sh = addr >> (OFFSET_BITS + SET_INDEX_BITS);
		return sh[TAG_BITS-1:0];
	endfunction

endpackage

// File: sv/snooping_coherent_cache_lookup.sv
// Top level of the snooping coherent cache lookup block.
// Holds the set store, the lookup and update logic, and the result register.
// Depends on sccl_pkg.

// One transfer is accepted per cycle while the output is not stalled; the set row
// is read from the set store at the input transfer, looked up and updated in the
// next cycle, and the result register loads when that stage advances, while the
// updated row is written back. A following transfer to the same set takes the
// freshly written row through a forwarding register, so back-to-back accesses cost
// nothing extra. Each set has a valid flag cleared by reset, so the block is ready
// right after reset with no clearing pass. The protocol register is written by
// cfg_we and cfg_wdata and should change only while the block is idle.
module snooping_coherent_cache_lookup
	import sccl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	set_row_t set_mem [NSETS];

	logic [1:0]       mode_q;
	logic [NSETS-1:0] set_valid_q;

	logic             s1_valid_s1;
	in_item_t         item_s1;
	logic [SET_W-1:0] set_s1;
	set_row_t         rd_row_s1;
	logic             row_vld_s1;
	logic             fwd_s1;
	set_row_t         fwd_row_s1;

	logic             accept;
	logic             s1_adv;
	logic [SET_W-1:0] in_set;

	set_row_t            row;
	set_row_t            new_row;
	logic [TAG_BITS-1:0] tag;
	logic                store;
	logic                snoop;
	logic                msi;
	logic                hit;
	logic                wb;
	logic                upg;
	logic [WAY_BITS-1:0] victim;
	logic [WAY_BITS-1:0] way;
	logic [WAY_BITS-1:0] fw_any;
	logic [WAY_BITS-1:0] fw_val;
	logic                found_any;
	logic                found_val;
	logic                do_bump;
	logic [WAY_BITS-1:0] bump_way;
	out_item_t           res;

	assign in_set   = set_of(in_data.address);
	assign s1_adv   = s1_valid_s1 && (!out_valid || out_ready);
	assign in_ready = !s1_valid_s1 || s1_adv;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NONE;
			set_valid_q <= '0;
			s1_valid_s1 <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (s1_adv) begin
				set_valid_q[set_s1] <= 1'b1;
			end
			if (accept) begin
				s1_valid_s1 <= 1'b1;
				fwd_s1      <= s1_adv && (in_set == set_s1);
			end else if (s1_adv) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			set_mem[set_s1] <= new_row;
		end
		if (accept) begin
			rd_row_s1 <= set_mem[in_set];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= in_data;
			set_s1     <= in_set;
			row_vld_s1 <= set_valid_q[in_set];
			fwd_row_s1 <= new_row;
		end
		if (s1_adv) begin
			out_data <= res;
		end
	end

	always_comb begin
		row   = fwd_s1 ? fwd_row_s1 : (row_vld_s1 ? rd_row_s1 : '0);
		tag   = tag_of(item_s1.address);
		store = item_s1.func == FN_STORE;
		snoop = (item_s1.func == FN_BUS_RD) || (item_s1.func == FN_BUS_RDX);
		msi   = mode_q[1];

		victim = ({1'b0, row.victim} >= (WAY_BITS + 1)'(WAYS)) ? '0 : row.victim;

		found_any = 1'b0;
		found_val = 1'b0;
		fw_any    = '0;
		fw_val    = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (row.tag[i] == tag) begin
				found_any = 1'b1;
				fw_any    = WAY_BITS'(i);
			end
			if (row.tag[i] == tag && row.st[i] == ST_VALID) begin
				found_val = 1'b1;
				fw_val    = WAY_BITS'(i);
			end
		end

		new_row  = row;
		hit      = 1'b0;
		wb       = 1'b0;
		upg      = 1'b0;
		way      = victim;
		do_bump  = 1'b0;

		if (msi) begin
			if (found_any && row.st[fw_any] != ST_INVALID) begin
				way = fw_any;
				if (row.st[fw_any] == ST_SHARED) begin
					if (store) begin
						new_row.st[fw_any]    = ST_MODIFIED;
						new_row.dirty[fw_any] = 1'b1;
						upg     = 1'b1;
						do_bump = 1'b1;
					end else begin
						hit = 1'b1;
						if (item_s1.func == FN_BUS_RDX) begin
							new_row.st[fw_any] = ST_INVALID;
						end else if (item_s1.func == FN_LOAD) begin
							do_bump = 1'b1;
						end
					end
				end else begin
					hit = 1'b1;
					if (snoop) begin
						new_row.st[fw_any] = (item_s1.func == FN_BUS_RDX) ?
							ST_INVALID : ST_SHARED;
						wb = row.dirty[fw_any];
						new_row.dirty[fw_any] = 1'b0;
					end else begin
						do_bump = 1'b1;
						if (store) begin
							new_row.dirty[fw_any] = 1'b1;
						end
					end
				end
			end else if (!snoop) begin
				if (found_any) begin
					way = fw_any;
				end else begin
					way = victim;
					wb  = row.dirty[victim];
					new_row.tag[victim] = tag;
				end
				new_row.st[way]    = store ? ST_MODIFIED : ST_SHARED;
				new_row.dirty[way] = store;
				do_bump = 1'b1;
			end
		end else begin
			if (found_val) begin
				hit = 1'b1;
				way = fw_val;
				if (snoop) begin
					if (mode_q == MODE_VI) begin
						new_row.st[fw_val]    = ST_INVALID;
						wb                    = row.dirty[fw_val];
						new_row.dirty[fw_val] = 1'b0;
					end
				end else begin
					if (store) begin
						new_row.dirty[fw_val] = 1'b1;
					end
					do_bump = 1'b1;
				end
			end else if (!snoop) begin
				wb                    = row.dirty[victim];
				new_row.dirty[victim] = store;
				new_row.tag[victim]   = tag;
				new_row.st[victim]    = ST_VALID;
				do_bump = 1'b1;
			end
		end

		bump_way = (way == WAY_BITS'(WAYS - 1)) ? '0 : WAY_BITS'(way + 1'b1);
		if (do_bump) begin
			new_row.victim = bump_way;
		end

		res.hit       = hit;
		res.writeback = wb;
		res.upgrade   = upg;
		res.way_used  = 2'(way);
	end

	a_upgrade_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.upgrade |-> !out_data.hit && !out_data.writeback)
		else $error("upgrade reported together with hit or writeback");

	a_upgrade_msi: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.upgrade |-> mode_q[1])
		else $error("upgrade reported outside MSI mode");

	a_no_flush_plain: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && snoop && mode_q == MODE_NONE |=> !out_data.writeback)
		else $error("snoop flushed a line with coherence off");

	a_set_marked: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> set_valid_q[$past(set_s1)])
		else $error("written set not marked valid");

endmodule
